// ===== src/ckf_pkg.sv =====
// ----------------------------------------------------------------------------
// Cyclic keyframe interpolator package
// Types and constants shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package ckf_pkg;

  localparam int POS_W       = 16;
  localparam int VAL_W       = 16;
  localparam int IDX_W       = 4;
  localparam int CFG_W       = 5;
  localparam int DIFF_W      = 17;
  localparam int PROD_W      = 33;
  localparam int NUM_W       = 34;
  localparam int QUO_W       = 17;
  localparam int RES_W       = 19;
  localparam int DIV_STEPS   = 17;
  localparam int STEP_W      = 5;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int ENTRY_W     = POS_W + VAL_W;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_MUL,
    ST_NUM,
    ST_DIV,
    ST_FIN
  } ckf_state_t;

  typedef struct packed {
    logic ram_wr;
    logic capture_key;
    logic cmp_en;
    logic cmp_first;
    logic cmp_last;
    logic prep;
    logic mul;
    logic div_init;
    logic div_step;
    logic load_out;
  } ckf_cmd_t;

  typedef struct packed {
    logic cmp_done;
    logic out_free;
  } ckf_status_t;

endpackage

// ===== src/ckf_ram.sv =====
// ----------------------------------------------------------------------------
// Keyframe RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module ckf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/ckf_dp.sv =====
// ----------------------------------------------------------------------------
// Cyclic keyframe interpolator datapath
// Keyframe storage, neighbour capture, span arithmetic, restoring divider
// and the output register.
// ----------------------------------------------------------------------------
module ckf_dp
  import ckf_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  ckf_cmd_t                                     cmd,
  output ckf_status_t                                  status,
  input  logic [$clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2)-1:0] rd_addr,
  input  logic [IN_TDATA_W-1:0]                        in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [OUT_TDATA_W-1:0]                       out_tdata,
  output logic [0:0]                                   out_tuser
);

  localparam int AW = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);

  logic [IDX_W-1:0]   wr_idx;
  logic [POS_W-1:0]   wr_pos;
  logic [VAL_W-1:0]   wr_val;
  logic [POS_W-1:0]   in_key;
  logic               wr_ok;
  logic [ENTRY_W-1:0] rd_data;
  logic [POS_W-1:0]   rd_pos;
  logic               hit;
  logic               up_found;

  logic [POS_W-1:0]   key_r;
  logic [ENTRY_W-1:0] prev_r, first_r, up_r, lo_r;
  logic               first_hit_r;
  logic [POS_W-1:0]   span_r, off_r;
  logic               ge_r;
  logic [DIFF_W-1:0]  d_r;
  logic [PROD_W-1:0]  prod_r;
  logic [POS_W-1:0]   rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic               ovf_r;
  logic               out_valid_r;
  logic [VAL_W-1:0]   out_val_r;
  logic               out_flag_r;

  logic signed [DIFF_W-1:0] vup_s, vlo_s, diff_s;
  logic [NUM_W-1:0]         num;
  logic [QUO_W-1:0]         num_hi;
  logic [QUO_W-1:0]         trial;
  logic                     trial_ge;
  logic [QUO_W-1:0]         q;
  logic signed [RES_W-1:0]  vlo_w, sum_w;
  logic [VAL_W-1:0]         res;

  assign wr_idx = in_tdata[3:0];
  assign wr_pos = in_tdata[19:4];
  assign wr_val = in_tdata[35:20];
  assign in_key = in_tdata[51:36];
  assign wr_ok  = 32'(wr_idx) < 32'(TABLE_DEPTH);

  ckf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.ram_wr && wr_ok),
    .wr_addr (AW'(wr_idx)),
    .wr_data ({wr_val, wr_pos}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // When the key sits at or below the first entry, the scan runs on to the
  // last entry, which becomes the lower neighbour.
  assign rd_pos   = rd_data[POS_W-1:0];
  assign hit      = key_r <= rd_pos;
  assign up_found = hit && !cmd.cmp_first && !first_hit_r;
  assign status.cmp_done = up_found || cmd.cmp_last;
  assign status.out_free = !out_valid_r || out_tready;

  assign vup_s  = DIFF_W'($signed(up_r[ENTRY_W-1:POS_W]));
  assign vlo_s  = DIFF_W'($signed(lo_r[ENTRY_W-1:POS_W]));
  assign diff_s = vup_s - vlo_s;

  assign num    = NUM_W'(prod_r) + NUM_W'(span_r >> 1);
  assign num_hi = num[NUM_W-1:NUM_W-QUO_W];

  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign trial_ge = trial >= QUO_W'(span_r);

  always_comb begin
    q     = ovf_r ? {QUO_W{1'b1}} : quo_r;
    vlo_w = RES_W'($signed(lo_r[ENTRY_W-1:POS_W]));
    if (ge_r) begin
      sum_w = vlo_w + $signed(RES_W'(q));
    end else begin
      sum_w = vlo_w - $signed(RES_W'(q));
    end
    if (sum_w > RES_W'(32767)) begin
      res = 16'h7fff;
    end else if (sum_w < -RES_W'(32768)) begin
      res = 16'h8000;
    end else begin
      res = sum_w[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_key) begin
      key_r <= in_key;
    end
    if (cmd.cmp_en) begin
      prev_r <= rd_data;
      if (cmd.cmp_first) begin
        first_r     <= rd_data;
        first_hit_r <= hit;
      end
      if (up_found) begin
        up_r <= rd_data;
        lo_r <= prev_r;
      end else if (cmd.cmp_last) begin
        up_r <= cmd.cmp_first ? rd_data : first_r;
        lo_r <= rd_data;
      end
    end
    if (cmd.prep) begin
      span_r <= up_r[POS_W-1:0] - lo_r[POS_W-1:0];
      off_r  <= key_r - lo_r[POS_W-1:0];
      ge_r   <= !diff_s[DIFF_W-1];
      d_r    <= diff_s[DIFF_W-1] ? DIFF_W'(-diff_s) : DIFF_W'(diff_s);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(d_r) * PROD_W'(off_r);
    end
    if (cmd.div_init) begin
      rem_r <= num_hi[POS_W-1:0];
      quo_r <= num[QUO_W-1:0];
      ovf_r <= num_hi >= QUO_W'(span_r);
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? POS_W'(trial - QUO_W'(span_r)) : trial[POS_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], trial_ge};
    end
    if (cmd.load_out) begin
      if (span_r == '0) begin
        out_val_r  <= lo_r[ENTRY_W-1:POS_W];
        out_flag_r <= 1'b1;
      end else begin
        out_val_r  <= res;
        out_flag_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_val_r;
  assign out_tuser[0] = out_flag_r;

endmodule

// ===== src/ckf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cyclic keyframe interpolator controller
// Sequences input acceptance, the table scan, the arithmetic steps and the
// hand-over to the output register; holds the entry count register.
// ----------------------------------------------------------------------------
module ckf_ctrl
  import ckf_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [0:0]                                   in_tuser,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [CFG_W-1:0]                             cfg_data,
  output ckf_cmd_t                                     cmd,
  input  ckf_status_t                                  status,
  output logic [$clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2)-1:0] rd_addr
);

  localparam int AW = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
  localparam int NW = $clog2(TABLE_DEPTH + 1) > AW ? $clog2(TABLE_DEPTH + 1) : AW;

  ckf_state_t        state_r, state_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [NW-1:0]     idx_r, idx_nxt;
  logic [NW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;

  assign in_tready = state_r == ST_IDLE;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign rd_addr   = idx_r[AW-1:0];

  always_comb begin
    n_nxt = n_r;
    if (cfg_valid) begin
      if (cfg_data == '0) begin
        n_nxt = NW'(1);
      end else if (32'(cfg_data) > 32'(TABLE_DEPTH)) begin
        n_nxt = NW'(TABLE_DEPTH);
      end else begin
        n_nxt = NW'(cfg_data);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    step_nxt    = step_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt     = '0;
        cmp_vld_nxt = 1'b0;
        if (accept && in_tuser[0] == KIND_LOOKUP) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_nxt     = idx_r + NW'(1);
        cmp_idx_nxt = idx_r;
        cmp_vld_nxt = 1'b1;
        if (cmp_vld_r && status.cmp_done) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_NUM;
      ST_NUM: begin
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.ram_wr      = accept && in_tuser[0] == KIND_WRITE;
    cmd.capture_key = accept && in_tuser[0] == KIND_LOOKUP;
    cmd.cmp_first   = cmp_idx_r == '0;
    cmd.cmp_last    = cmp_idx_r == n_r - NW'(1);
    case (state_r)
      ST_SCAN:  cmd.cmp_en   = cmp_vld_r;
      ST_PREP:  cmd.prep     = 1'b1;
      ST_MUL:   cmd.mul      = 1'b1;
      ST_NUM:   cmd.div_init = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FIN:   cmd.load_out = status.out_free;
      default:  cmd.cmp_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      n_r       <= NW'(1);
      idx_r     <= '0;
      cmp_idx_r <= '0;
      cmp_vld_r <= 1'b0;
      step_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      n_r       <= n_nxt;
      idx_r     <= idx_nxt;
      cmp_idx_r <= cmp_idx_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      step_r    <= step_nxt;
    end
  end

endmodule

// ===== src/cyclic_keyframe_interpolator.sv =====
// ----------------------------------------------------------------------------
// Cyclic keyframe interpolator
// A write word stores one keyframe; the block stays ready for the next word.
// A lookup word scans entries from index zero, one per cycle on the single
// read port of the keyframe RAM, until it finds the first position at or
// above the key, then interpolates between that entry and the one before it
// (wrapping round the cycle) using a 17-step restoring divider. When the key
// is at or below the first position, the scan runs on to the last entry in
// use, which is the earlier neighbour. The result sits in an output register,
// so the next word is taken while it waits. A zero span returns the earlier
// value with the flag raised.
// ----------------------------------------------------------------------------
module cyclic_keyframe_interpolator
  import ckf_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // entry_index, entry_position, entry_value, lookup_key, zero padding
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // interpolated_value
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // span_was_zero
  output logic [0:0]             out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);

  ckf_cmd_t        cmd;
  ckf_status_t     status;
  logic [AW-1:0]   rd_addr;

  ckf_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rd_addr   (rd_addr)
  );

  ckf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .rd_addr    (rd_addr),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/tb_cyclic_keyframe_interpolator.sv =====
// ----------------------------------------------------------------------------
// Testbench for the cyclic keyframe interpolator
// Streams keyframe writes and lookups into the block, predicts every lookup
// result from a behavioural copy of the keyframe table, and checks each result
// word on the output stream against the oldest prediction. Directed tests cover
// wrap-round, zero spans, unsorted tables and saturation. Random traffic then
// runs under several table sizes and idle patterns, with one long output stall.
// ----------------------------------------------------------------------------
module tb_cyclic_keyframe_interpolator;
  import ckf_pkg::*;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             zero;
  } lookup_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = KIND_WRITE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;

  logic [POS_W-1:0]        key_pos [16];
  logic signed [VAL_W-1:0] key_val [16];
  logic [CFG_W-1:0]        model_entries_in_use = 5'd1;
  lookup_result_t          pending_results [$];

  int send_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_off_request = 0;
  int hold_left = 0;
  int words_sent = 0;
  int lookups_sent = 0;
  int results_checked = 0;
  int settings_used = 0;
  int err_count = 0;

  cyclic_keyframe_interpolator #(.TABLE_DEPTH(16)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_entries();
    int n;
    n = int'(model_entries_in_use);
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  function automatic lookup_result_t interpolate_key(logic [POS_W-1:0] key);
    lookup_result_t r;
    int n, up, lo, k;
    logic [POS_W-1:0] span, off;
    longint vlo, vup, d, q, s;
    n = active_entries();
    up = n;
    for (k = 0; k < n; k++) begin
      if (up == n && key <= key_pos[k]) up = k;
    end
    if (up == n) begin
      up = 0;
      lo = n - 1;
    end else if (up > 0) begin
      lo = up - 1;
    end else begin
      lo = n - 1;
    end
    span = key_pos[up] - key_pos[lo];
    off = key - key_pos[lo];
    vlo = longint'(key_val[lo]);
    vup = longint'(key_val[up]);
    if (span == 0) begin
      r.value = key_val[lo];
      r.zero = 1'b1;
    end else begin
      d = (vup >= vlo) ? vup - vlo : vlo - vup;
      q = (d * longint'(off) + longint'(span / 2)) / longint'(span);
      if (q > 64'h1FFFF) q = 64'h1FFFF;
      s = (vup >= vlo) ? vlo + q : vlo - q;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      r.value = s[VAL_W-1:0];
      r.zero = 1'b0;
    end
    return r;
  endfunction

  // One word on the input stream; tvalid stays high afterwards unless the
  // next call idles first.
  task automatic send_word(input logic kind, input logic [IDX_W-1:0] idx,
                           input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val,
                           input logic [POS_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'b0000, key, val, pos, idx};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (kind == KIND_WRITE) begin
      key_pos[idx] = pos;
      key_val[idx] = val;
    end else begin
      lookups_sent++;
      pending_results.push_back(interpolate_key(key));
    end
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
    send_word(KIND_WRITE, idx, pos, val, POS_W'($urandom));
  endtask

  task automatic lookup(input logic [POS_W-1:0] key);
    send_word(KIND_LOOKUP, IDX_W'($urandom), POS_W'($urandom), VAL_W'($urandom), key);
  endtask

  // The register is only written once the block has gone quiet.
  task automatic set_entries_in_use(input logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_entries_in_use = value;
    settings_used++;
  endtask

  task automatic write_sorted_table();
    int n, p, step_max, k;
    n = active_entries();
    p = $urandom_range(0, 4095);
    step_max = (65535 - p) / n;
    for (k = 0; k < n; k++) begin
      write_entry(4'(k), 16'(p), VAL_W'($urandom));
      if ($urandom_range(9) != 0) p = p + $urandom_range(1, step_max);
    end
  endtask

  task automatic random_traffic(input int count);
    int i, r;
    logic [POS_W-1:0] key;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        write_sorted_table();
      end else if (r < 16) begin
        write_entry(IDX_W'($urandom), POS_W'($urandom), VAL_W'($urandom));
      end else begin
        if ($urandom_range(3) == 0)
          key = key_pos[$urandom_range(active_entries() - 1)] + 16'($urandom_range(1));
        else
          key = POS_W'($urandom);
        lookup(key);
      end
    end
  endtask

  task automatic test_single_entry();
    write_entry(4'd0, 16'h8000, 16'sh8000);
    lookup(16'h0000);
    lookup(16'hFFFF);
  endtask

  task automatic test_two_entry_table();
    set_entries_in_use(5'd2);
    write_entry(4'd1, 16'hC000, 16'sh7FFF);
    lookup(16'h8000);
    lookup(16'hA000);
    lookup(16'hFFFF);
    lookup(16'h0000);
  endtask

  task automatic test_unsorted_table();
    write_entry(4'd0, 16'hE000, 16'sh8000);
    lookup(16'h1000);
    lookup(16'hD000);
    write_entry(4'd0, 16'hE000, 16'sh7FFF);
    write_entry(4'd1, 16'hC000, 16'sh8000);
    lookup(16'h1000);
  endtask

  task automatic test_zero_span_and_limits();
    write_entry(4'd1, 16'hE000, 16'sd1234);
    lookup(16'h7000);
    write_entry(4'd15, 16'hFFFF, 16'sh7FFF);
    set_entries_in_use(5'd0);
    lookup(16'h4000);
  endtask

  task automatic run_random_phase(input int send_pct, input int sink_pct,
                                  input logic [CFG_W-1:0] c0, input logic [CFG_W-1:0] c1,
                                  input logic [CFG_W-1:0] c2);
    send_idle_pct = send_pct;
    sink_idle_pct = sink_pct;
    set_entries_in_use(c0);
    write_sorted_table();
    random_traffic(100);
    set_entries_in_use(c1);
    write_sorted_table();
    random_traffic(100);
    set_entries_in_use(c2);
    write_sorted_table();
    random_traffic(100);
  endtask

  task automatic test_output_backpressure();
    int i;
    send_idle_pct = 0;
    sink_idle_pct = 0;
    set_entries_in_use(5'd16);
    hold_off_request = 500;
    for (i = 0; i < 12; i++) lookup(POS_W'($urandom));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_off_request > 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    lookup_result_t expected;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("Result word with no lookup outstanding: value %0d, flag %0d",
               $signed(out_tdata), out_tuser);
        err_count++;
      end else begin
        expected = pending_results.pop_front();
        results_checked++;
        if (out_tdata !== expected.value) begin
          $error("interpolated_value: expected %0d, got %0d",
                 $signed(expected.value), $signed(out_tdata));
          err_count++;
        end
        if (out_tuser[0] !== expected.zero) begin
          $error("span_was_zero: expected %0d, got %0d", expected.zero, out_tuser[0]);
          err_count++;
        end
      end
    end
  end

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_entry();
    test_two_entry_table();
    test_unsorted_table();
    test_zero_span_and_limits();

    set_entries_in_use(5'd16);
    write_sorted_table();
    run_random_phase(32, 71, 5'd16, 5'd5, 5'd31);
    run_random_phase(71, 32, 5'd1, 5'd17, 5'd9);
    run_random_phase(0, 0, 5'd0, 5'd16, 5'($urandom_range(2, 15)));
    test_output_backpressure();

    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d lookup results never arrived", pending_results.size());
      err_count++;
    end

    $display("Sent %0d words, %0d of them lookups, over %0d table-size settings.",
             words_sent, lookups_sent, settings_used);
    $display("Checked %0d results, covering wrap-round, zero spans, saturation and a stall.",
             results_checked);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ckf_pkg.sv
src/ckf_ram.sv
src/ckf_dp.sv
src/ckf_ctrl.sv
src/cyclic_keyframe_interpolator.sv
tb/tb_cyclic_keyframe_interpolator.sv
